// ===== rtl/sfm_pkg.sv =====
package sfm_pkg;

    // Sizing
    localparam int MAX_PATTERN   = 16;
    localparam int POSITION_BITS = 16;
    localparam int WIN_DEPTH     = MAX_PATTERN - 1;
    localparam int PAT_IDX_W     = $clog2(MAX_PATTERN);

    // Fixed field widths
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int LEN_W         = 5;
    localparam int POS_W         = 16;
    localparam int PAT_REG_BYTES = 16;
    localparam int EXT_W         = POSITION_BITS + POS_W;

    localparam logic [POS_W-1:0]         POS_FIELD_MAX = {POS_W{1'b1}};
    localparam logic [POSITION_BITS-1:0] COUNT_MAX     = {POSITION_BITS{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_end;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
        logic             position_overflow;
    } out_item_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// ===== rtl/sfm_cell.sv =====
module sfm_cell
    import sfm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] byte_in,
    input  logic [7:0] pattern_byte,
    input  logic       in_use,
    output logic [7:0] byte_out,
    output logic       match
);

    logic [7:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            byte_reg <= 8'd0;
        end else if (ctrl.shift) begin
            byte_reg <= byte_in;
        end
    end

    // Unused cells never veto a match
    assign match    = !in_use || (byte_reg == pattern_byte);
    assign byte_out = byte_reg;

endmodule

// ===== rtl/sfm_out_buf.sv =====
module sfm_out_buf
    import sfm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  out_item_t load_data,
    output logic      can_load,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    logic      valid_reg;
    out_item_t data_reg;

    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid   = valid_reg;
    assign m_payload = data_reg;

endmodule

// ===== rtl/substring_first_match_top.sv =====
// Streaming first-occurrence substring search.
// Input channel (s_valid/s_ready/s_payload): one text byte per transfer, or an
// end item (is_end = 1) that closes the current string.
// Result channel (m_valid/m_ready/m_payload): at most one result per string, either
// the start offset of the first match or, on the end item, found only for an empty pattern.
// Pattern registers are written through cfg_write_en/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block does not enforce; unknown indexes are dropped.
// A result is registered and is on m_valid in the cycle after the transfer that caused it.
// Throughput: one item per cycle while s_ready is high; the window of 15 byte cells and the parallel
// compare are updated on every accepted byte.
// The result sits in a single output register. s_ready drops only while that
// register is full and m_ready is low, so a stalled receiver holds up input
// only while a result is waiting in that register.
// Reset (aresetn low, synchronous) clears the pattern registers, the byte
// cells, the position counter and all flags; no clearing pass is needed.
module substring_first_match_top
    import sfm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // text in
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_payload,
    // results out
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_payload
);

    // ---------------- configuration registers ----------------
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]      pat_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else if (cfg_write_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                REG_PATTERN_LEN:  pat_len_reg  <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [2*CFG_DATA_W-1:0] pat_all;
    logic [7:0]              pat_bytes [PAT_REG_BYTES];

    assign pat_all = {pat_high_reg, pat_low_reg};

    always_comb begin
        for (int i = 0; i < PAT_REG_BYTES; i++) begin
            pat_bytes[i] = pat_all[i*8 +: 8];
        end
    end

    // lengths beyond the window saturate
    logic [LEN_W-1:0] act_len;
    assign act_len = (pat_len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_reg;

    logic [LEN_W-1:0] last_idx;
    assign last_idx = act_len - LEN_W'(1);

    // ---------------- per-string state ----------------
    logic [POSITION_BITS-1:0] count_reg;
    logic                     ovf_reg;
    logic                     reported_reg;

    logic       s_fire;
    logic       out_can_load;
    logic       is_byte;
    logic       is_end;
    cell_ctrl_t cell_ctrl;

    assign s_ready   = out_can_load;
    assign s_fire    = s_valid && s_ready;
    assign is_end    = s_fire && s_payload.is_end;
    assign is_byte   = s_fire && !s_payload.is_end;
    assign cell_ctrl = '{shift: is_byte, clear: is_end};

    // ---------------- window: chain of byte cells ----------------
    // Cell k holds the byte k+1 places back and is checked against
    // pattern byte act_len-2-k.
    logic [7:0]         chain   [WIN_DEPTH+1];
    logic [WIN_DEPTH-1:0] cell_match;

    assign chain[0] = s_payload.text_byte;

    for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
        logic [LEN_W-1:0] pidx;
        logic             used;
        assign pidx = act_len - LEN_W'(k + 2);
        assign used = (LEN_W'(k + 2) <= act_len);

        sfm_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (cell_ctrl),
            .byte_in      (chain[k]),
            .pattern_byte (pat_bytes[pidx[PAT_IDX_W-1:0]]),
            .in_use       (used),
            .byte_out     (chain[k+1]),
            .match        (cell_match[k])
        );
    end

    // ---------------- match decision ----------------
    logic                     len_zero;
    logic                     enough;
    logic                     cur_match;
    logic                     hit;
    logic [POSITION_BITS-1:0] start_pos;
    logic                     start_big;
    logic                     emit;
    out_item_t                result;

    assign len_zero  = (act_len == '0);
    assign enough    = ovf_reg || (count_reg >= POSITION_BITS'(last_idx));
    assign cur_match = (pat_bytes[last_idx[PAT_IDX_W-1:0]] == s_payload.text_byte);
    assign hit       = len_zero || (enough && cur_match && (&cell_match));
    assign start_pos = len_zero ? '0 : (count_reg - POSITION_BITS'(last_idx));
    assign start_big = (EXT_W'(start_pos) > EXT_W'(POS_FIELD_MAX));

    always_comb begin
        result = '{found: 1'b0, match_position: '0, position_overflow: ovf_reg};
        emit   = 1'b0;
        if (!reported_reg) begin
            if (s_payload.is_end) begin
                emit         = 1'b1;
                result.found = len_zero;
                if (len_zero && ovf_reg) begin
                    result.match_position = POS_FIELD_MAX;
                end
            end else if (hit) begin
                emit                     = 1'b1;
                result.found             = 1'b1;
                result.position_overflow = ovf_reg || start_big;
                result.match_position    = (ovf_reg || start_big) ? POS_FIELD_MAX
                                                                  : start_pos[POS_W-1:0];
            end
        end
    end

    // ---------------- counter and flags ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn || is_end) begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            reported_reg <= 1'b0;
        end else if (is_byte) begin
            if (count_reg == COUNT_MAX) begin
                ovf_reg <= 1'b1;
            end else begin
                count_reg <= count_reg + POSITION_BITS'(1);
            end
            if (emit) begin
                reported_reg <= 1'b1;
            end
        end
    end

    // ---------------- result register ----------------
    sfm_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_fire && emit),
        .load_data (result),
        .can_load  (out_can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ===== tb/sv/sfm_tb_pkg.sv =====
`timescale 1ns / 100ps
package sfm_tb_pkg;
    import sfm_pkg::*;

    // Tracks the search state of the block and holds the results it owes.
    class match_scoreboard;
        logic [CFG_DATA_W-1:0]    pat_low;
        logic [CFG_DATA_W-1:0]    pat_high;
        logic [LEN_W-1:0]         pat_len;
        logic [7:0]               window [WIN_DEPTH];
        logic [POSITION_BITS-1:0] byte_count;
        bit                       count_overflowed;
        bit                       reported;
        out_item_t                expected_matches [$];
        int unsigned              errors;

        function new();
            pat_low  = '0;
            pat_high = '0;
            pat_len  = '0;
            errors   = 0;
            clear_string();
        endfunction

        function void clear_string();
            foreach (window[k]) window[k] = 8'h00;
            byte_count       = '0;
            count_overflowed = 1'b0;
            reported         = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PATTERN_LOW:  pat_low  = data;
                REG_PATTERN_HIGH: pat_high = data;
                REG_PATTERN_LEN:  pat_len  = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] pattern_byte(int k);
            return (k < 8) ? pat_low[8*k +: 8] : pat_high[8*(k-8) +: 8];
        endfunction

        function int unsigned pending();
            return expected_matches.size();
        endfunction

        function void queue_match(bit hit, logic [POS_W-1:0] pos, bit ovf);
            out_item_t r;
            r.found             = hit;
            r.match_position    = (hit && ovf) ? POS_FIELD_MAX : pos;
            r.position_overflow = ovf;
            expected_matches.push_back(r);
        endfunction

        // Advance the search by one accepted input transfer.
        function void note_transfer(in_item_t item);
            int                       n;
            int                       k;
            bit                       hit;
            logic [POSITION_BITS-1:0] start;
            n = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
            if (item.is_end) begin
                if (!reported) queue_match(n == 0, '0, count_overflowed);
                clear_string();
                return;
            end
            if (!reported) begin
                start = '0;
                if (n == 0) begin
                    hit = 1'b1;
                end else begin
                    hit = count_overflowed || (byte_count >= n - 1);
                    if (pattern_byte(n - 1) != item.text_byte) hit = 1'b0;
                    for (k = 1; k < n; k++)
                        if (pattern_byte(n - 1 - k) != window[k - 1]) hit = 1'b0;
                    start = byte_count - POSITION_BITS'(n - 1);
                end
                if (hit) begin
                    queue_match(1'b1, start, count_overflowed);
                    reported = 1'b1;
                end
            end
            for (k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k - 1];
            window[0] = item.text_byte;
            if (byte_count == COUNT_MAX) count_overflowed = 1'b1;
            else byte_count++;
        endfunction

        function void flag_field(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_matches.size() == 0) begin
                flag_field("unexpected result", 32'h0, 32'(got));
                return;
            end
            want = expected_matches.pop_front();
            if (got.found !== want.found)
                flag_field("found", 32'(want.found), 32'(got.found));
            if (got.match_position !== want.match_position)
                flag_field("match_position", 32'(want.match_position),
                           32'(got.match_position));
            if (got.position_overflow !== want.position_overflow)
                flag_field("position_overflow", 32'(want.position_overflow),
                           32'(got.position_overflow));
        endfunction
    endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
    import sfm_pkg::*;
    import sfm_tb_pkg::*;

    // Index 3 is not decoded by the block; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 750;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    in_item_t              s_payload    = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    out_item_t             m_payload;

    match_scoreboard board;

    bit          tx_gaps_on    = 1'b1;
    bit          rx_stalls_on  = 1'b1;
    int          rx_stall_left = 0;
    int unsigned items_sent    = 0;

    // Current pattern as loaded into the block, plus a small alphabet the
    // random text is drawn from so that matches and near misses are common.
    logic [7:0]  pat_bytes [MAX_PATTERN];
    int unsigned pat_used = 0;
    logic [7:0]  text_alphabet [4];
    int          alpha_size = 1;

    substring_first_match_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_payload    (m_payload)
    );

    always #5 aclk = ~aclk;

    // Result side: check every transfer against the oldest expectation, and
    // stall the receiver in short random bursts while stalls are enabled.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_payload);
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_ready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 6) == 0) begin
            rx_stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // One input transfer. An optional random gap with valid low goes in front;
    // valid is otherwise left high so back-to-back items stream at full rate.
    task automatic send_item(input logic [7:0] value, input logic end_flag);
        in_item_t item;
        item.text_byte = value;
        item.is_end    = end_flag;
        if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        board.note_transfer(item);
        items_sent++;
    endtask

    // The text byte of an end item is don't-care; keep it random.
    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_chars(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++) send_item(txt[i], 1'b0);
    endtask

    // Drop valid and wait until every owed result has come back, then keep
    // idling in case the last transfer produced nothing.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Leaves the write enable high; the caller drops it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge aclk);
        board.write_register(idx, data);
    endtask

    task automatic load_pattern(input logic [CFG_DATA_W-1:0] len_word);
        logic [CFG_DATA_W-1:0] low_word;
        logic [CFG_DATA_W-1:0] high_word;
        int k;
        for (k = 0; k < 8; k++) begin
            low_word[8*k +: 8]  = pat_bytes[k];
            high_word[8*k +: 8] = pat_bytes[k + 8];
        end
        write_reg(REG_PATTERN_LOW, low_word);
        write_reg(REG_PATTERN_HIGH, high_word);
        write_reg(REG_PATTERN_LEN, len_word);
        cfg_write_en <= 1'b0;
        // lengths above the maximum act as the maximum
        pat_used = (len_word[LEN_W-1:0] > MAX_PATTERN) ? MAX_PATTERN : len_word[LEN_W-1:0];
    endtask

    task automatic set_pattern_text(input string txt);
        int k;
        for (k = 0; k < txt.len(); k++) pat_bytes[k] = txt[k];
        load_pattern(CFG_DATA_W'(txt.len()));
    endtask

    // New random pattern and alphabet. Mostly short patterns; some empty,
    // some full length, some with an out-of-range length code. Upper bits of
    // the length word are junk, which the block must ignore.
    task automatic pick_pattern();
        logic [CFG_DATA_W-1:0] len_word;
        int k;
        int fill;
        alpha_size = $urandom_range(1, 4);
        for (k = 0; k < 4; k++) text_alphabet[k] = 8'($urandom_range(0, 255));
        fill = $urandom_range(0, 9);
        if (fill == 0) text_alphabet[0] = 8'h00;
        if (fill == 1) text_alphabet[0] = 8'hFF;
        for (k = 0; k < MAX_PATTERN; k++) begin
            if (fill == 0)      pat_bytes[k] = 8'h00;
            else if (fill == 1) pat_bytes[k] = 8'hFF;
            else                pat_bytes[k] = text_alphabet[$urandom_range(0, alpha_size - 1)];
        end
        len_word = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0: begin
                len_word[LEN_W-1:0] = '0;
            end
            1: begin
                len_word[LEN_W-1:0] = LEN_W'(MAX_PATTERN);
            end
            2: begin
                len_word[LEN_W-1:0] = LEN_W'($urandom_range(MAX_PATTERN + 1, 31));
            end
            default: begin
                len_word[LEN_W-1:0] = LEN_W'($urandom_range(1, 6));
            end
        endcase
        if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, {$urandom(), $urandom()});
        load_pattern(len_word);
    endtask

    function automatic logic [7:0] pick_text_byte();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return text_alphabet[$urandom_range(0, alpha_size - 1)];
    endfunction

    // One string: random text with, most of the time, the pattern or a
    // prefix of it planted somewhere, then the end item. Now and then the
    // pattern is swapped partway through while the block is idle.
    task automatic random_string();
        int n;
        int i;
        int k;
        int plant_at;
        int plant_len;
        int change_at;
        n         = $urandom_range(0, 24);
        plant_at  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, n) : -1;
        plant_len = ($urandom_range(0, 2) != 0) ? pat_used : $urandom_range(0, pat_used);
        change_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n) : -1;
        for (i = 0; i <= n; i++) begin
            if (i == change_at) begin
                wait_idle();
                pick_pattern();
            end
            if (i == plant_at)
                for (k = 0; k < plant_len; k++) send_item(pat_bytes[k], 1'b0);
            if (i < n) send_item(pick_text_byte(), 1'b0);
        end
        send_end();
    endtask

    initial begin
        int random_stop;
        board = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part ---
        // Pattern registers reset to empty: the first item of a string,
        // an end item or a byte, reports a match at offset 0.
        write_reg(REG_UNUSED, {CFG_DATA_W{1'b1}});
        cfg_write_en <= 1'b0;
        send_end();
        send_item(8'h00, 1'b0);  // zero byte is text, not a terminator
        send_item(8'hFF, 1'b0);  // already reported, nothing
        send_end();              // end after a report, nothing
        wait_idle();

        // single zero byte as the pattern
        pat_bytes[0] = 8'h00;
        load_pattern(1);
        send_item(8'h41, 1'b0);
        send_item(8'h00, 1'b0);  // match at 1
        send_end();

        // only the first of repeated occurrences is reported
        wait_idle();
        set_pattern_text("ab");
        send_chars("xabab");
        send_end();
        // string ends without a match
        send_chars("a");
        send_end();

        // pattern change partway through a string takes effect from the
        // next transfer on
        wait_idle();
        set_pattern_text("xyz");
        send_chars("qx");
        wait_idle();
        set_pattern_text("x");
        send_chars("x");         // match at 2
        send_end();

        // --- random part ---
        wait_idle();
        pick_pattern();
        random_stop = items_sent + RANDOM_ITEMS;
        while (items_sent < random_stop) begin
            // a quarter of the strings run with no idling on that side
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                pick_pattern();
            end
            random_string();
        end

        // --- closing strings, no idling from here on ---
        wait_idle();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (4) random_string();

        wait_idle();
        repeat (10) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hang guard, several times the slowest legal run.
    initial begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sfm_pkg.sv
rtl/sfm_cell.sv
rtl/sfm_out_buf.sv
rtl/substring_first_match_top.sv
tb/sv/sfm_tb_pkg.sv
tb/sv/testbench.sv
